>>> rtl/core/surs_pkg.sv
// ----------------------------------------------------------------------------
// surs_pkg: shared types and tables for the stepper sequencer
// Holds the sequencer state and configuration structs, register indexes,
// reset values and the half-step coil tables.
// ----------------------------------------------------------------------------
package surs_pkg;

    localparam int unsigned PHASE_STEPS_DEF = 8;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned CFG_DATA_W      = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELOCK     = 2'd2;

    localparam logic [7:0]  STEP_DELAY_RST = 8'd2;
    localparam logic [15:0] PAUSE_RST      = 16'd3000;
    localparam logic [7:0]  RELOCK_RST     = 8'd4;

    typedef struct packed {
        logic [15:0] wait_left;
        logic [3:0]  phase_index;
        logic [7:0]  turns_left;
        logic        reverse_run;
        logic        running;
        logic [3:0]  coil_drive;
    } t_state;

    typedef struct packed {
        logic [7:0]  step_delay_ticks;
        logic [15:0] pause_ticks;
        logic [7:0]  relock_turns;
    } t_cfg;

    // clockwise half-step coil pattern
    function automatic logic [3:0] cw_coil(input logic [2:0] idx);
        logic [3:0] pat;
        case (idx)
            3'd0:    pat = 4'h9;
            3'd1:    pat = 4'h1;
            3'd2:    pat = 4'h3;
            3'd3:    pat = 4'h2;
            3'd4:    pat = 4'h6;
            3'd5:    pat = 4'h4;
            3'd6:    pat = 4'hC;
            3'd7:    pat = 4'h8;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

    // counterclockwise half-step coil pattern
    function automatic logic [3:0] ccw_coil(input logic [2:0] idx);
        logic [3:0] pat;
        case (idx)
            3'd0:    pat = 4'h8;
            3'd1:    pat = 4'hC;
            3'd2:    pat = 4'h4;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h2;
            3'd5:    pat = 4'h3;
            3'd6:    pat = 4'h1;
            3'd7:    pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

>>> rtl/core/surs_in_if.sv
// ----------------------------------------------------------------------------
// surs_in_if: request channel of the stepper sequencer
// Valid/ready channel carrying a tick or a start request.
// ----------------------------------------------------------------------------
interface surs_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic       direction;
    logic [7:0] turns;

    modport source (output valid, output mode, output direction, output turns, input ready);
    modport sink   (input valid, input mode, input direction, input turns, output ready);
endinterface

>>> rtl/core/surs_out_if.sv
// ----------------------------------------------------------------------------
// surs_out_if: result channel of the stepper sequencer
// Valid/ready channel carrying coil drive and run status.
// ----------------------------------------------------------------------------
interface surs_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] coil_pattern;
    logic       busy_res;
    logic       done_res;

    modport source (output valid, output coil_pattern, output busy_res, output done_res,
                    input ready);
    modport sink   (input valid, input coil_pattern, input busy_res, input done_res,
                    output ready);
endinterface

>>> rtl/core/stepper_unlock_relock_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_unlock_relock_sequencer: half-step stepper drive with relock
// Drives four unipolar coils through a half-step table, clockwise, or
// counterclockwise followed by a pause and a clockwise relock run.
//
// Channels: i_req carries one request per handshake: mode 0 is a time tick,
// mode 1 starts a run with a direction and a turn count. o_res returns one
// result per request: the coil pattern after that request, busy while a run
// or pause is in progress, and done on the request that ends a clockwise run.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data:
// index 0 step delay, 1 pause length, 2 relock turns.
//
// The state and the result register update at the edge that takes the
// request. One request is taken per cycle while the result is not stalled;
// the state update is a wait counter decrement and a table lookup.
// When the receiver stalls, the result holds in its register and i_req.ready
// drops until the result is taken; a new request is taken in the same cycle
// the held one leaves. Reset idles the sequencer with coils off, clears the
// result valid flag and restores the configuration defaults.
// ----------------------------------------------------------------------------
module stepper_unlock_relock_sequencer #(
    parameter int unsigned PHASE_STEPS = surs_pkg::PHASE_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    surs_in_if.sink                         i_req,
    surs_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [surs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [surs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import surs_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_cfg       r_cfg;
    logic       r_out_valid;
    logic [3:0] r_coil;
    logic       r_busy;
    logic       r_done;
    logic       n_done;
    logic       req_take;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign req_take    = i_req.valid && i_req.ready;

    surs_step_logic #(
        .PHASE_STEPS (PHASE_STEPS)
    ) u_step (
        .i_state     (r_state),
        .i_cfg       (r_cfg),
        .i_mode      (i_req.mode),
        .i_direction (i_req.direction),
        .i_turns     (i_req.turns),
        .o_state     (n_state),
        .o_done      (n_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_delay_ticks <= STEP_DELAY_RST;
            r_cfg.pause_ticks      <= PAUSE_RST;
            r_cfg.relock_turns     <= RELOCK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STEP_DELAY: r_cfg.step_delay_ticks <= i_cfg_data[7:0];
                REG_PAUSE:      r_cfg.pause_ticks      <= i_cfg_data;
                REG_RELOCK:     r_cfg.relock_turns     <= i_cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (req_take) begin
                r_state <= n_state;
            end
            // drop valid once taken unless a new request refills it
            if (req_take) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_coil <= n_state.coil_drive;
            r_busy <= n_state.running;
            r_done <= n_done;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.coil_pattern = r_coil;
    assign o_res.busy_res     = r_busy;
    assign o_res.done_res     = r_done;

endmodule

>>> rtl/core/surs_step_logic.sv
// ----------------------------------------------------------------------------
// surs_step_logic: next-state logic of the stepper sequencer
// Applies one tick or start request to the current state: counts down the
// wait, steps through the half-step table, repeats turns, and handles the
// pause and relock after a counterclockwise run.
// ----------------------------------------------------------------------------
module surs_step_logic #(
    parameter int unsigned PHASE_STEPS = surs_pkg::PHASE_STEPS_DEF
) (
    input  surs_pkg::t_state i_state,
    input  surs_pkg::t_cfg   i_cfg,
    input  logic             i_mode,
    input  logic             i_direction,
    input  logic [7:0]       i_turns,
    output surs_pkg::t_state o_state,
    output logic             o_done
);
    import surs_pkg::*;

    localparam logic [3:0] PHASE_LIM = 4'(PHASE_STEPS);

    t_state      s;
    logic        do_act;
    logic [15:0] step_wait;
    logic [15:0] pause_wait;

    // a delay of zero behaves as one
    assign step_wait  = (i_cfg.step_delay_ticks == 8'd0) ? 16'd1
                                                         : {8'd0, i_cfg.step_delay_ticks};
    assign pause_wait = (i_cfg.pause_ticks == 16'd0) ? 16'd1 : i_cfg.pause_ticks;

    always_comb begin
        s      = i_state;
        do_act = 1'b0;
        o_done = 1'b0;

        if (i_mode) begin
            // start: abandon any current run and drive the first step at once
            s.reverse_run = i_direction;
            s.turns_left  = i_turns;
            s.phase_index = '0;
            s.running     = 1'b1;
            do_act        = 1'b1;
        end else if (s.running) begin
            if (s.wait_left > 16'd1) begin
                s.wait_left = s.wait_left - 16'd1;
            end else begin
                s.wait_left = '0;
                do_act      = 1'b1;
            end
        end

        if (do_act) begin
            if (s.phase_index < PHASE_LIM) begin
                s.coil_drive  = s.reverse_run ? ccw_coil(s.phase_index[2:0])
                                              : cw_coil(s.phase_index[2:0]);
                s.phase_index = s.phase_index + 4'd1;
                s.wait_left   = step_wait;
            end else if (s.turns_left != 8'd0) begin
                // repeat the sequence: one extra delay, coils unchanged
                s.turns_left  = s.turns_left - 8'd1;
                s.phase_index = '0;
                s.wait_left   = step_wait;
            end else begin
                s.coil_drive = '0;
                if (s.reverse_run) begin
                    // pause, then relock clockwise
                    s.reverse_run = 1'b0;
                    s.phase_index = '0;
                    s.turns_left  = i_cfg.relock_turns;
                    s.wait_left   = pause_wait;
                end else begin
                    s.running   = 1'b0;
                    s.wait_left = '0;
                    o_done      = 1'b1;
                end
            end
        end
    end

    assign o_state = s;

endmodule

>>> rtl/core/surs_checker.sv
// ----------------------------------------------------------------------------
// surs_checker: port-level checks for the stepper sequencer
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module surs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_req_mode,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [3:0] i_res_coil,
    input logic       i_res_busy,
    input logic       i_res_done
);

    // result register comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_coil)
            && $stable(i_res_busy) && $stable(i_res_done))
        else $error("stalled result changed");

    // requests flow whenever the result side is not stalled
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_res_valid && !i_res_ready) |-> i_req_ready)
        else $error("request side blocked without a stall");

    // a finished run shows idle with coils off
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_done |-> !i_res_busy && i_res_coil == 4'h0)
        else $error("done with coils on or still busy");

    // a start request always yields a busy result
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_mode |=> i_res_valid && i_res_busy)
        else $error("start did not report busy");

endmodule

bind stepper_unlock_relock_sequencer surs_checker u_surs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_mode  (i_req.mode),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_coil  (o_res.coil_pattern),
    .i_res_busy  (o_res.busy_res),
    .i_res_done  (o_res.done_res)
);
